/* design/ptwa_pkg.sv */
// shared types and codes for the peer table with aging
// no dependencies
package ptwa_pkg;

  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int STATUS_W   = 3;
  localparam int OUT_CNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_ANNOUNCE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK     = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_VERSION = 2'd1,
    CFG_RELOAD  = 2'd2,
    CFG_STEP    = 2'd3
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED     = 3'd0,
    ST_INSERTED    = 3'd1,
    ST_FULL        = 3'd2,
    ST_BAD_MAGIC   = 3'd3,
    ST_BAD_VERSION = 3'd4,
    ST_TICK_DONE   = 3'd5,
    ST_HIT         = 3'd6,
    ST_MISS        = 3'd7
  } status_t;

  localparam logic [15:0] RELOAD_RST = 16'd32;
  localparam logic [15:0] STEP_RST   = 16'd4;

  // per-entry payload kept in the table memory
  typedef struct packed {
    logic [31:0] group;
    logic        conductor;
    logic [63:0] uptime;
    logic [7:0]  mode;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the request fields
    logic exec;   // compare, update table, register result
  } ptwa_cmd_t;

endpackage

/* design/peer_table_with_aging.sv */
// the result strobe is high in the response state, which follows the execute state;
// the execute state does all address compares, lifetime updates and the payload
// memory read, whose data is registered
// a new start is taken in the cycle the result is shown; the receiver cannot stall
// reset (rst_n low, synchronous) empties the table and loads config defaults,
// no clearing pass; top level joins controller and datapath
module peer_table_with_aging import ptwa_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_req_type,
  input  logic [31:0]           in_msg_magic,
  input  logic [7:0]            in_msg_version,
  input  logic [31:0]           in_peer_ip,
  input  logic [31:0]           in_sync_group,
  input  logic                  in_conductor_flag,
  input  logic [63:0]           in_peer_uptime,
  input  logic [7:0]            in_peer_mode,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [6:0]            out_entry_count,
  output logic [6:0]            out_expired_count,
  output logic [31:0]           out_found_sync_group,
  output logic                  out_found_conductor,
  output logic [63:0]           out_found_uptime,
  output logic [7:0]            out_found_mode,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ptwa_cmd_t cmd;

  ptwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ptwa_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_req_type          (in_req_type),
    .in_msg_magic         (in_msg_magic),
    .in_msg_version       (in_msg_version),
    .in_peer_ip           (in_peer_ip),
    .in_sync_group        (in_sync_group),
    .in_conductor_flag    (in_conductor_flag),
    .in_peer_uptime       (in_peer_uptime),
    .in_peer_mode         (in_peer_mode),
    .out_status           (out_status),
    .out_entry_count      (out_entry_count),
    .out_expired_count    (out_expired_count),
    .out_found_sync_group (out_found_sync_group),
    .out_found_conductor  (out_found_conductor),
    .out_found_uptime     (out_found_uptime),
    .out_found_mode       (out_found_mode)
  );

endmodule

/* design/ptwa_ctrl.sv */
// controller state machine for the peer table: sequences capture, execute and result
// depends on ptwa_pkg
module ptwa_ctrl import ptwa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output ptwa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // next item may be taken while the result is on the ports
        state_nxt = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = (state_r == S_RESP);
  assign cmd.load  = start && !busy;
  assign cmd.exec  = (state_r == S_EXEC);

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && cmd.exec))
    else $error("accepted transfer did not enter execute");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.exec))
    else $error("result strobe without a preceding execute cycle");

endmodule

/* design/ptwa_dp.sv */
// datapath of the peer table: config registers, address lanes, lifetimes,
// payload memory and result registers; depends on ptwa_pkg
module ptwa_dp import ptwa_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptwa_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]            in_req_type,
  input  logic [31:0]           in_msg_magic,
  input  logic [7:0]            in_msg_version,
  input  logic [31:0]           in_peer_ip,
  input  logic [31:0]           in_sync_group,
  input  logic                  in_conductor_flag,
  input  logic [63:0]           in_peer_uptime,
  input  logic [7:0]            in_peer_mode,
  output logic [2:0]            out_status,
  output logic [6:0]            out_entry_count,
  output logic [6:0]            out_expired_count,
  output logic [31:0]           out_found_sync_group,
  output logic                  out_found_conductor,
  output logic [63:0]           out_found_uptime,
  output logic [7:0]            out_found_mode
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // config
  logic [31:0] magic_cfg_r;
  logic [7:0]  version_cfg_r;
  logic [15:0] reload_cfg_r;
  logic [15:0] step_cfg_r;

  // captured request
  logic [1:0]  req_r;
  logic [31:0] magic_r;
  logic [7:0]  version_r;
  logic [31:0] ip_r;
  entry_t      data_r;

  // table
  logic [ENTRIES-1:0] valid_r;
  logic [31:0]        ip_tab_r [ENTRIES];
  logic [15:0]        life_r   [ENTRIES];
  entry_t             mem      [ENTRIES];
  logic [CNT_W-1:0]   count_r;

  // result
  status_t          status_r;
  logic [CNT_W-1:0] expired_r;
  logic             hit_r;
  entry_t           rd_r;

  logic [ENTRIES-1:0] match_vec, expire_vec;
  logic               hit_any, free_any;
  logic [IDX_W-1:0]   hit_idx, free_idx, wr_idx;
  logic [CNT_W-1:0]   exp_cnt;
  logic               is_ann, is_tick, ann_ok, wr_en, ins;
  status_t            status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_cfg_r   <= '0;
      version_cfg_r <= '0;
      reload_cfg_r  <= RELOAD_RST;
      step_cfg_r    <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MAGIC:   magic_cfg_r   <= cfg_wdata;
        CFG_VERSION: version_cfg_r <= cfg_wdata[7:0];
        CFG_RELOAD:  reload_cfg_r  <= cfg_wdata[15:0];
        CFG_STEP:    step_cfg_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r          <= in_req_type;
      magic_r        <= in_msg_magic;
      version_r      <= in_msg_version;
      ip_r           <= in_peer_ip;
      data_r.group     <= in_sync_group;
      data_r.conductor <= in_conductor_flag;
      data_r.uptime    <= in_peer_uptime;
      data_r.mode      <= in_peer_mode;
    end
  end

  // parallel lane compares and lowest-index encoders
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    exp_cnt  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i]  = valid_r[i] && (ip_tab_r[i] == ip_r);
      expire_vec[i] = valid_r[i] && (life_r[i] <= step_cfg_r);
      exp_cnt       = exp_cnt + CNT_W'(expire_vec[i]);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx  = IDX_W'(i);
      if (!valid_r[i])  free_idx = IDX_W'(i);
    end
    hit_any  = |match_vec;
    free_any = ~&valid_r;
  end

  always_comb begin
    is_ann  = (req_r == REQ_ANNOUNCE);
    is_tick = (req_r == REQ_TICK);
    ann_ok  = is_ann && (magic_r == magic_cfg_r) && (version_r == version_cfg_r);
    wr_en   = ann_ok && (hit_any || free_any);
    ins     = ann_ok && !hit_any && free_any;
    wr_idx  = hit_any ? hit_idx : free_idx;
    priority if (is_ann && (magic_r != magic_cfg_r)) status_nxt = ST_BAD_MAGIC;
    else if (is_ann && (version_r != version_cfg_r))  status_nxt = ST_BAD_VERSION;
    else if (is_ann && hit_any)                       status_nxt = ST_UPDATED;
    else if (is_ann && free_any)                      status_nxt = ST_INSERTED;
    else if (is_ann)                                  status_nxt = ST_FULL;
    else if (is_tick)                                 status_nxt = ST_TICK_DONE;
    else if (hit_any)                                 status_nxt = ST_HIT;
    else                                              status_nxt = ST_MISS;
  end

  // address and lifetime lanes
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (ins && (free_idx == IDX_W'(i))) ip_tab_r[i] <= ip_r;
        if (wr_en && (wr_idx == IDX_W'(i))) begin
          life_r[i] <= reload_cfg_r;
        end else if (is_tick && valid_r[i] && !expire_vec[i]) begin
          life_r[i] <= life_r[i] - step_cfg_r;
        end
      end
    end
  end

  // payload memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_idx] <= data_r;
    if (cmd.exec)          rd_r        <= mem[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      if (ins) begin
        valid_r[free_idx] <= 1'b1;
        count_r           <= count_r + CNT_W'(1);
      end else if (is_tick) begin
        valid_r <= valid_r & ~expire_vec;
        count_r <= count_r - exp_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= status_nxt;
      expired_r <= is_tick ? exp_cnt : '0;
      hit_r     <= !is_ann && !is_tick && hit_any;
    end
  end

  assign out_status           = status_r;
  assign out_entry_count      = OUT_CNT_W'(count_r);
  assign out_expired_count    = OUT_CNT_W'(expired_r);
  assign out_found_sync_group = hit_r ? rd_r.group : '0;
  assign out_found_conductor  = hit_r && rd_r.conductor;
  assign out_found_uptime     = hit_r ? rd_r.uptime : '0;
  assign out_found_mode       = hit_r ? rd_r.mode : '0;

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(count_r) == 32'($countones(valid_r))))
    else $error("entry count out of step with valid bits");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && ins) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not add one entry");

endmodule
